### hw/rtl/pipc_pkg.sv
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and constants for the polygon/circle point test
// Sizes, register codes, vertex record and edge status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pipc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_W    = $clog2(MAX_VERTICES);
    localparam int N_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 4;
    localparam int VC_W      = 5;
    localparam int RAD_W     = COORD_BITS - 1;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = ((IDX_W + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } vertex_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_COUNT = 2'd0,
        REG_CENTER_X     = 2'd1,
        REG_CENTER_Y     = 2'd2,
        REG_RADIUS       = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // edge pipe status toward the sequencer
    typedef struct packed {
        logic busy;   // an edge is still in flight
        logic hit;    // this cycle an edge is counted
    } edge_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pipc_vtx_ram.sv
// ----------------------------------------------------------------------------
// pipc_vtx_ram: vertex table
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_vtx_ram
    import pipc_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  vertex_t           wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output vertex_t           rd_data
);

    vertex_t mem [MAX_VERTICES];
    vertex_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/pipc_edge.sv
// ----------------------------------------------------------------------------
// pipc_edge: ray/edge crossing test
// Stages: differences, cross products, then a combinational sign and range decision.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_edge
    import pipc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_vld,
    input  vertex_t    va,
    input  vertex_t    vb,
    input  coord_t     px,
    input  coord_t     py,
    output edge_stat_t stat
);

    // stage A: differences
    logic                     a_vld_reg;
    logic signed [DIFF_W-1:0] d_a_reg, vy_a_reg, vx_a_reg, ex_a_reg;
    // stage B: products and flags
    logic                     b_vld_reg;
    logic signed [PROD_W-1:0] p1_b_reg, p2_b_reg;
    logic                     dz_b_reg, dpos_b_reg, rng_b_reg;

    logic signed [PROD_W-1:0] p1_next, p2_next;
    logic                     dz_next, dpos_next, rng_next;
    logic signed [PROD_W:0]   n_cross;
    logic                     hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d_a_reg    <= DIFF_W'(vb.y) - DIFF_W'(va.y);
        vy_a_reg   <= DIFF_W'(py) - DIFF_W'(va.y);
        vx_a_reg   <= DIFF_W'(px) - DIFF_W'(va.x);
        ex_a_reg   <= DIFF_W'(vb.x) - DIFF_W'(va.x);
        p1_b_reg   <= p1_next;
        p2_b_reg   <= p2_next;
        dz_b_reg   <= dz_next;
        dpos_b_reg <= dpos_next;
        rng_b_reg  <= rng_next;
    end

    always_comb begin
        p1_next   = PROD_W'(vx_a_reg) * PROD_W'(d_a_reg);
        p2_next   = PROD_W'(ex_a_reg) * PROD_W'(vy_a_reg);
        dz_next   = (d_a_reg == '0);
        dpos_next = !d_a_reg[DIFF_W-1] && !dz_next;
        // vy must lie between 0 and D, both ends included
        if (dpos_next) begin
            rng_next = !vy_a_reg[DIFF_W-1] && (vy_a_reg <= d_a_reg);
        end else begin
            rng_next = (vy_a_reg[DIFF_W-1] || (vy_a_reg == '0)) && (vy_a_reg >= d_a_reg);
        end
    end

    always_comb begin
        n_cross = (PROD_W+1)'(p1_b_reg) - (PROD_W+1)'(p2_b_reg);
        if (dpos_b_reg) begin
            hit = n_cross[PROD_W] || (n_cross == '0);
        end else begin
            hit = !n_cross[PROD_W];
        end
        stat.hit  = b_vld_reg && !dz_b_reg && rng_b_reg && hit;
        stat.busy = a_vld_reg || b_vld_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/pipc_circ.sv
// ----------------------------------------------------------------------------
// pipc_circ: circle prefilter
// Squared distance to the center against radius squared, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_circ
    import pipc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_vld,
    input  coord_t           px,
    input  coord_t           py,
    input  coord_t           cx,
    input  coord_t           cy,
    input  logic [RAD_W-1:0] radius,
    output logic             res_vld,
    output logic             in_circ
);

    logic                     s1_vld_reg, s2_vld_reg, res_vld_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [RAD_W-1:0]         r_reg;
    logic [PROD_W-1:0]        sx_reg, sy_reg;
    logic [2*RAD_W-1:0]       r2_reg;
    logic                     in_circ_reg;

    logic signed [PROD_W-1:0] sx_next, sy_next;
    logic [PROD_W:0]          sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            res_vld_reg <= s2_vld_reg;
        end
    end

    always_comb begin
        sx_next = PROD_W'(dx_reg) * PROD_W'(dx_reg);
        sy_next = PROD_W'(dy_reg) * PROD_W'(dy_reg);
        sum     = (PROD_W+1)'(sx_reg) + (PROD_W+1)'(sy_reg);
    end

    always_ff @(posedge aclk) begin
        dx_reg      <= DIFF_W'(px) - DIFF_W'(cx);
        dy_reg      <= DIFF_W'(py) - DIFF_W'(cy);
        r_reg       <= radius;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        r2_reg      <= (2*RAD_W)'(r_reg) * (2*RAD_W)'(r_reg);
        in_circ_reg <= (sum < (PROD_W+1)'(r2_reg));
    end

    assign res_vld = res_vld_reg;
    assign in_circ = in_circ_reg;

endmodule

`default_nettype wire

### hw/rtl/point_in_polygon_circle_prefilter.sv
// ----------------------------------------------------------------------------
// point_in_polygon_circle_prefilter: ray-casting point test with circle gate
// Vertex table in a synchronous RAM, swept one vertex per cycle per query.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes requests. s_tuser = 0 loads a vertex into the table slot
//   given by the index field, with no result. s_tuser = 1 queries a point and
//   yields exactly one result on the m_* channel.
//   cfg_* writes vertex_count, center_x, center_y and radius; always ready.
//   Write config only while the block is idle.
// Sequencing:
//   A query with n usable vertices (vertex_count clamped to the table depth)
//   shows its result once the sweep and both test pipes are done and the
//   output register is free. The table RAM has one read port, so the sweep
//   reads one vertex at a time; the edge pipe and the three-stage circle test
//   run overlapped with it. A new request is taken once the result is in the
//   output register; loads are taken one after another while the block is idle.
// Reset:
//   aresetn (sync, low) clears control and config registers. The table holds
//   garbage until loaded; querying unloaded slots gives undefined results.
// Stall:
//   The result sits in the output register until m_tready; the block goes on
//   taking loads and one more query meanwhile, and holds that query's result
//   back while the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_circle_prefilter
    import pipc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request: [3:0] vertex_index, [19:4] point_x, [35:20] point_y, rest zero
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: [0] command
    input  logic                  s_tuser,
    // result: [0] inside_res, [1] in_circle, [5:2] crossings, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // config write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    // ---------------- request fields ----------------
    cmd_t             s_cmd;
    logic [IDX_W-1:0] s_idx;
    coord_t           s_x, s_y;
    logic             s_acc, load_acc, query_acc;

    assign s_cmd = cmd_t'(s_tuser);
    assign s_idx = s_tdata[IDX_W-1:0];
    assign s_x   = s_tdata[IDX_W +: COORD_BITS];
    assign s_y   = s_tdata[IDX_W+COORD_BITS +: COORD_BITS];

    // ---------------- config registers ----------------
    logic [VC_W-1:0]  vcount_reg, vcount_next;
    coord_t           cx_reg, cx_next, cy_reg, cy_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic             cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_comb begin
        vcount_next = vcount_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rad_next    = rad_reg;
        if (cfg_acc) begin
            case (cfg_reg_t'(cfg_index))
                REG_VERTEX_COUNT: vcount_next = cfg_data[VC_W-1:0];
                REG_CENTER_X:     cx_next     = cfg_data;
                REG_CENTER_Y:     cy_next     = cfg_data;
                REG_RADIUS:       rad_next    = cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    state_t           state_reg, state_next;
    coord_t           px_reg, py_reg;
    logic [N_W-1:0]   n_reg, n_next, n_clamp;
    logic [N_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic             rd_vld_reg, first_reg, first_next;
    vertex_t          prev_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             circ_done_reg, circ_done_next;
    logic             in_circ_reg, in_circ_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic             finish;
    logic [CNT_W-1:0] crossings;

    // RAM hookup
    logic    ram_re;
    vertex_t ram_rdata;

    // unit status
    edge_stat_t est;
    logic       circ_vld, circ_in;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign load_acc  = s_acc && (s_cmd == CMD_LOAD) && (32'(s_idx) < MAX_VERTICES);
    assign query_acc = s_acc && (s_cmd == CMD_QUERY);
    assign ram_re    = (state_reg == S_READ);

    assign n_clamp = (32'(vcount_reg) > MAX_VERTICES) ? N_W'(MAX_VERTICES)
                                                      : N_W'(vcount_reg);

    // Loads only land in IDLE and the sweep starts the cycle after a query is
    // taken, so a table read never races a write to the same slot.
    pipc_vtx_ram u_ram (
        .aclk    (aclk),
        .wr_en   (load_acc),
        .wr_addr (ADDR_W'(s_idx)),
        .wr_data ({s_y, s_x}),
        .rd_en   (ram_re),
        .rd_addr (rd_cnt_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // edge (v[i-1], v[i]) goes in as soon as v[i] returns from the RAM
    pipc_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (rd_vld_reg && !first_reg),
        .va      (prev_reg),
        .vb      (ram_rdata),
        .px      (px_reg),
        .py      (py_reg),
        .stat    (est)
    );

    pipc_circ u_circ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (query_acc),
        .px      (s_x),
        .py      (s_y),
        .cx      (cx_reg),
        .cy      (cy_reg),
        .radius  (rad_reg),
        .res_vld (circ_vld),
        .in_circ (circ_in)
    );

    // result is ready when the sweep and both pipes are empty and the
    // output register can take it
    assign finish = (state_reg == S_DRAIN) && !rd_vld_reg && !est.busy
                    && circ_done_reg && (!m_tvalid_reg || m_tready);

    assign crossings = in_circ_reg ? cnt_reg : '0;

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        rd_cnt_next    = rd_cnt_reg;
        first_next     = 1'b0;
        cnt_next       = cnt_reg;
        circ_done_next = circ_done_reg;
        in_circ_next   = in_circ_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (est.hit) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (circ_vld) begin
            circ_done_next = 1'b1;
            in_circ_next   = circ_in;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (query_acc) begin
                    n_next         = n_clamp;
                    rd_cnt_next    = '0;
                    cnt_next       = '0;
                    circ_done_next = 1'b0;
                    state_next     = (n_clamp == '0) ? S_DRAIN : S_READ;
                end
            end
            S_READ: begin
                first_next  = (rd_cnt_reg == '0);
                rd_cnt_next = rd_cnt_reg + N_W'(1);
                if (rd_cnt_reg == n_reg - N_W'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (finish) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({crossings, in_circ_reg,
                                                in_circ_reg & cnt_reg[0]});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rad_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            circ_done_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rad_reg       <= rad_next;
            rd_vld_reg    <= ram_re;
            circ_done_reg <= circ_done_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (query_acc) begin
            px_reg <= s_x;
            py_reg <= s_y;
        end
        if (rd_vld_reg) begin
            prev_reg <= ram_rdata;
        end
        n_reg       <= n_next;
        rd_cnt_reg  <= rd_cnt_next;
        first_reg   <= first_next;
        cnt_reg     <= cnt_next;
        in_circ_reg <= in_circ_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // no table read or edge activity while taking new requests
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!rd_vld_reg && !est.busy))
        else $error("edge pipe active while idle");

    // a result only follows a completed circle check
    a_circ_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(circ_done_reg))
        else $error("result issued before circle test finished");

    // crossings cannot outnumber the edges of the chain
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> ((cnt_reg == '0) || (N_W'(cnt_reg) < n_reg)))
        else $error("crossing count exceeds edge count");

    // a held result is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !finish)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: point_in_polygon_circle_prefilter testbench
// Loads vertex chains and sends point queries through the stream port, and
// predicts every verdict from a local copy of the table and the registers.
// Register settings change between phases, once the block has drained.
// ----------------------------------------------------------------------------

module tb;
    import pipc_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 30;     // outlasts a full 16-vertex sweep
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_REQUESTS = 40;
    localparam int MAX_REPORTS    = 30;

    // one request on the s_ channel
    typedef struct packed {
        cmd_t             cmd;
        logic [IDX_W-1:0] slot;
        coord_t           x;
        coord_t           y;
    } request_t;

    // one verdict on the m_ channel
    typedef struct packed {
        logic             inside_res;
        logic             in_circle;
        logic [CNT_W-1:0] crossings;
    } verdict_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [3:0] vertex_index, [19:4] point_x, [35:20] point_y, rest zero
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // [0] command
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] inside_res, [1] in_circle, [5:2] crossings, rest zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data  = '0;

    point_in_polygon_circle_prefilter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    request_t request_q[$];     // requests waiting for the driver
    verdict_t verdict_q[$];     // predicted verdicts, oldest first

    // predictor's copy of the block, updated at each accepted write / load
    vertex_t          vtx_tbl[MAX_VERTICES];
    logic [VC_W-1:0]  cur_count  = '0;
    coord_t           cur_cx     = '0;
    coord_t           cur_cy     = '0;
    logic [RAD_W-1:0] cur_radius = '0;

    // generation-side view: which slots hold a vertex, how many are in use
    logic [MAX_VERTICES-1:0] gen_loaded = '0;
    int gen_count = 0;

    int  sent_total  = 0;       // requests handed to the driver
    int  taken_total = 0;       // requests accepted by the block
    int  errors      = 0;
    int  cycles      = 0;
    bit  calm        = 1'b0;    // no idling on either side
    bit  s_fire      = 1'b0;    // request accepted at the last rising edge
    bit  cfg_took    = 1'b0;    // register write accepted at the last rising edge
    int  send_gap    = 0;
    int  recv_gap    = 0;

    // coverage tallies
    int n_loads = 0, n_queries = 0, n_in_circle = 0, n_inside = 0;
    int n_settings = 0, top_crossings = 0;

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line each, capped so a broken block stays readable
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        if (errors < MAX_REPORTS)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Verdict predictor: circle gate, then ray toward +x over the open chain.
    // Edge test is the sign of vx*D - ex*vy, all terms fit easily in 64 bits.
    // ------------------------------------------------------------------------
    function automatic verdict_t classify_point(coord_t px, coord_t py);
        longint dx, dy, ax, ay, bx, by, d, vx, vy, ex, n_prod;
        int nv, hits;
        bit hit;
        verdict_t v;
        dx = longint'(px) - longint'(cur_cx);
        dy = longint'(py) - longint'(cur_cy);
        v.in_circle = (dx * dx + dy * dy) < (longint'(cur_radius) * longint'(cur_radius));
        hits = 0;
        // counts above the table depth use the whole table
        nv = (cur_count > MAX_VERTICES) ? MAX_VERTICES : int'(cur_count);
        if (v.in_circle) begin
            for (int i = 0; i + 1 < nv; i++) begin
                ax = vtx_tbl[i].x;
                ay = vtx_tbl[i].y;
                bx = vtx_tbl[i+1].x;
                by = vtx_tbl[i+1].y;
                d  = by - ay;
                vy = longint'(py) - ay;
                vx = longint'(px) - ax;
                ex = bx - ax;
                n_prod = vx * d - ex * vy;
                // horizontal edges never count; both edge ends are included
                if (d > 0)
                    hit = (vy >= 0) && (vy <= d) && (n_prod <= 0);
                else if (d < 0)
                    hit = (vy <= 0) && (vy >= d) && (n_prod >= 0);
                else
                    hit = 1'b0;
                if (hit)
                    hits++;
            end
        end
        v.inside_res = v.in_circle && hits[0];
        v.crossings  = hits[CNT_W-1:0];
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: register shadow, result check, then prediction of new requests
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        request_t req;
        verdict_t got, want;
        s_fire   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_VERTEX_COUNT: cur_count  = cfg_data[VC_W-1:0];
                    REG_CENTER_X:     cur_cx     = coord_t'(cfg_data);
                    REG_CENTER_Y:     cur_cy     = coord_t'(cfg_data);
                    REG_RADIUS:       cur_radius = cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.inside_res = m_tdata[0];
                got.in_circle  = m_tdata[1];
                got.crossings  = m_tdata[2 +: CNT_W];
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", int'(m_tdata), -1);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.inside_res != want.inside_res)
                        report_mismatch("inside_res", got.inside_res, want.inside_res);
                    if (got.in_circle != want.in_circle)
                        report_mismatch("in_circle", got.in_circle, want.in_circle);
                    if (got.crossings != want.crossings)
                        report_mismatch("crossings", got.crossings, want.crossings);
                end
            end
            if (s_tvalid && s_tready) begin
                req.cmd  = cmd_t'(s_tuser);
                req.slot = s_tdata[IDX_W-1:0];
                req.x    = coord_t'(s_tdata[IDX_W +: COORD_BITS]);
                req.y    = coord_t'(s_tdata[IDX_W+COORD_BITS +: COORD_BITS]);
                taken_total++;
                if (req.cmd == CMD_LOAD) begin
                    vtx_tbl[req.slot] = '{y: req.y, x: req.x};
                    n_loads++;
                end else begin
                    want = classify_point(req.x, req.y);
                    verdict_q.push_back(want);
                    n_queries++;
                    n_in_circle += want.in_circle;
                    n_inside    += want.inside_res;
                    if (want.crossings > top_crossings)
                        top_crossings = want.crossings;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: pulls the next request when the channel is free, with idle bursts
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 15);
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                nxt = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= S_TDATA_W'({nxt.y, nxt.x, nxt.slot});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (recv_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 15);
            if (recv_gap != 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers (called at a falling edge)
    // ------------------------------------------------------------------------
    task automatic write_reg(cfg_reg_t r, logic [COORD_BITS-1:0] v);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        do @(negedge aclk); while (!cfg_took);
    endtask

    // raw register words; upper bits beyond each register's width are don't-care
    task automatic set_config(logic [15:0] vc, logic [15:0] cx, logic [15:0] cy,
                              logic [15:0] rad);
        write_reg(REG_VERTEX_COUNT, vc);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, rad);
        cfg_valid = 1'b0;
        gen_count = (vc[VC_W-1:0] > MAX_VERTICES) ? MAX_VERTICES : int'(vc[VC_W-1:0]);
        n_settings++;
    endtask

    task automatic queue_load(logic [IDX_W-1:0] slot, coord_t x, coord_t y);
        request_q.push_back('{cmd: CMD_LOAD, slot: slot, x: x, y: y});
        gen_loaded[slot] = 1'b1;
        sent_total++;
    endtask

    // a query that would sweep an empty slot becomes a load of that slot
    task automatic queue_query(coord_t x, coord_t y);
        for (int k = 0; k < gen_count; k++) begin
            if (!gen_loaded[k]) begin
                queue_load(IDX_W'(k), x, y);
                return;
            end
        end
        request_q.push_back('{cmd: CMD_QUERY, slot: IDX_W'($urandom), x: x, y: y});
        sent_total++;
    endtask

    // coordinate within span of c, optionally on a 64-unit grid, clamped
    function automatic coord_t near(coord_t c, int span, bit grid);
        int off, v;
        off = int'($urandom_range(0, 2 * span)) - span;
        if (grid)
            off = (off / 64) * 64;
        v = int'(c) + off;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // block idle: everything sent was taken and answered, then let a sweep finish
    task automatic wait_drained();
        @(negedge aclk);
        while (taken_total != sent_total || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int     span, pick, vc;
        bit     grid;
        coord_t cx, cy;
        logic [RAD_W-1:0] rad;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // --- directed ---
        // reset registers: zero radius rejects everything; extreme vertices
        queue_query(0, 0);
        queue_load(0, -32768, -32768);
        queue_load(1, 32767, 32767);
        wait_drained();

        // single vertex: no edges; farthest corner falls outside the circle
        set_config(16'd1, 16'd0, 16'd0, 16'd32767);
        queue_query(0, 0);
        queue_query(32767, -32768);
        wait_drained();

        // one long diagonal edge: left of it, right of it, exactly on it
        set_config(16'd2, 16'd0, 16'd0, 16'd32767);
        queue_query(-10, 0);
        queue_query(10, 0);
        queue_query(5, 5);
        wait_drained();

        // square chain with horizontal edges; ray through a shared vertex
        set_config(16'd5, 16'd128, 16'd128, 16'd32767);
        queue_load(0, 0, 0);
        queue_load(1, 256, 0);
        queue_load(2, 256, 256);
        queue_load(3, 0, 256);
        queue_load(4, 0, 0);
        queue_query(128, 128);
        queue_query(-100, 0);
        wait_drained();

        // circle edge: distance equal to the radius is outside
        set_config(16'd0, 16'd0, 16'd0, 16'd256);
        queue_query(256, 0);
        queue_query(255, 0);
        queue_query(0, -256);
        wait_drained();

        // --- random phases: a fresh chain, then mostly nearby queries ---
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph == RAND_PHASES - 1);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       vc = 0;
                1:       vc = 1;
                2:       vc = $urandom_range(MAX_VERTICES + 1, 31);
                3:       vc = MAX_VERTICES;
                default: vc = $urandom_range(2, MAX_VERTICES - 1);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                cx = coord_t'($urandom);
                cy = coord_t'($urandom);
            end else begin
                cx = near(0, 4096, 1'b0);
                cy = near(0, 4096, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                rad = RAD_W'($urandom);
            else
                rad = RAD_W'($urandom_range(64, 2048));
            // register extremes in the first phases
            if (ph == 0) begin
                vc = MAX_VERTICES; cx = -32768; cy = 32767; rad = '1;
            end else if (ph == 1) begin
                vc = 31; cx = 32767; cy = -32768; rad = '0;
            end else if (ph == 2) begin
                vc = 17; rad = '1;
            end
            set_config({11'($urandom), 5'(vc)}, cx, cy, {1'($urandom), rad});
            span = (rad < 64) ? 64 : int'(rad);
            grid = $urandom_range(0, 1);
            for (int k = 0; k < gen_count; k++)
                queue_load(IDX_W'(k), near(cx, span, grid), near(cy, span, grid));
            repeat (PHASE_REQUESTS - gen_count) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    queue_query(near(cx, span, grid), near(cy, span, grid));
                else if (pick == 7)
                    queue_query(coord_t'($urandom), coord_t'($urandom));
                else if (pick == 8)
                    queue_load(IDX_W'($urandom), near(cx, span, grid), near(cy, span, grid));
                else
                    queue_load(IDX_W'($urandom), coord_t'($urandom), coord_t'($urandom));
            end
            wait_drained();
        end

        if (verdict_q.size() != 0)
            report_mismatch("results never delivered", 0, verdict_q.size());
        $display("covered %0d vertex loads and %0d point queries over %0d register settings",
                 n_loads, n_queries, n_settings);
        $display("queries: %0d within circle, %0d inside shape, up to %0d crossings",
                 n_in_circle, n_inside, top_crossings);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### point_in_polygon_circle_prefilter.f
hw/rtl/pipc_pkg.sv
hw/rtl/pipc_vtx_ram.sv
hw/rtl/pipc_edge.sv
hw/rtl/pipc_circ.sv
hw/rtl/point_in_polygon_circle_prefilter.sv
verif/tb.sv
